// ----- src/tcp_pkg.sv -----
// shared types and constants for the text cursor placement block
// no dependencies; imported by every module of the block
`default_nettype none

package tcp_pkg;

   // command codes of an input item
   localparam logic CMD_BEGIN = 1'b0;
   localparam logic CMD_CHAR  = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_DRAW   = 2'd0;
   localparam logic [1:0] KIND_DONE   = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   // character codes with special handling
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // width of the placement count in a queued job, holds up to the largest tab stop
   localparam int OP_COUNT_W = 4;

   // depth of the job queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic       command;
      logic [2:0] start_line;
      logic [4:0] start_column;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] draw_line;
      logic [4:0] draw_column;
      logic [7:0] glyph_code;
      logic [6:0] drawn_total;
      logic       last;
   } rsp_type;

   // one job for the back end: a run of placements or a single status result
   typedef struct packed {
      logic [1:0]            kind;
      logic [2:0]            line;
      logic [4:0]            column;
      logic [7:0]            glyph;
      logic [6:0]            total;
      logic [OP_COUNT_W-1:0] count;
   } op_type;

endpackage

`default_nettype wire

// ----- src/tcp_front.sv -----
// front end: takes input items, keeps the cursor state, turns each item into at most one job
// depends on tcp_pkg
`default_nettype none

module tcp_front #(
   parameter int TEXT_LINES   = 4,
   parameter int TEXT_COLUMNS = 16,
   parameter int TAB_STOP     = 4,
   parameter int BUFFER_BYTES = 256
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_accept,
   input  wire tcp_pkg::req_type req_data,
   output logic                 op_push,
   output tcp_pkg::op_type      op_data
);
   import tcp_pkg::*;

   localparam int LINE_W   = $clog2(TEXT_LINES + 2);
   localparam int COL_W    = $clog2(TEXT_COLUMNS + 2);
   localparam int DRAWN_W  = $clog2(TEXT_LINES * TEXT_COLUMNS + 1);
   localparam int BYTES_W  = $clog2(BUFFER_BYTES);
   localparam int PH_W     = $clog2(TAB_STOP);
   localparam int CNT_W    = $clog2(TAB_STOP + 1);
   localparam int N_W      = (COL_W > CNT_W) ? COL_W : CNT_W;
   localparam int TABLE_N  = 2 ** COL_W;

   logic               active_ff, active_in;
   logic [LINE_W-1:0]  line_ff, line_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [DRAWN_W-1:0] drawn_ff, drawn_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;

   logic [PH_W-1:0]    phase_table [TABLE_N];
   logic [N_W-1:0]     spaces;
   logic [N_W-1:0]     room;
   logic [N_W-1:0]     run_n;
   logic [COL_W-1:0]   col_after;
   logic               begin_ok;

   // column phase within its tab stop, fixed at elaboration
   for (genvar i = 0; i < TABLE_N; i++) begin : g_phase
      assign phase_table[i] = (i == 0) ? '0 : PH_W'((i - 1) % TAB_STOP);
   end

   always_comb begin
      begin_ok  = (int'(req_data.start_line) >= 1) && (int'(req_data.start_line) <= TEXT_LINES)
               && (int'(req_data.start_column) >= 1)
               && (int'(req_data.start_column) <= TEXT_COLUMNS);
      spaces    = N_W'(TAB_STOP) - N_W'(phase_table[col_ff]);
      room      = N_W'(TEXT_COLUMNS + 1) - N_W'(col_ff);
      run_n     = (req_data.char_code == CHAR_TAB) ? ((spaces < room) ? spaces : room)
                                                   : N_W'(1);
      col_after = col_ff + COL_W'(run_n);
   end

   always_comb begin
      active_in      = active_ff;
      line_in        = line_ff;
      col_in         = col_ff;
      drawn_in       = drawn_ff;
      bytes_in       = bytes_ff;
      op_push        = 1'b0;
      op_data.kind   = KIND_DRAW;
      op_data.line   = 3'(line_ff);
      op_data.column = 5'(col_ff);
      op_data.glyph  = req_data.char_code;
      op_data.total  = '0;
      op_data.count  = OP_COUNT_W'(1);
      if (req_accept) begin
         if (req_data.command == CMD_BEGIN) begin
            if (begin_ok) begin
               active_in = 1'b1;
               line_in   = LINE_W'(req_data.start_line);
               col_in    = COL_W'(req_data.start_column);
               drawn_in  = '0;
               bytes_in  = '0;
            end else begin
               active_in      = 1'b0;
               op_push        = 1'b1;
               op_data.kind   = KIND_REJECT;
               op_data.line   = '0;
               op_data.column = '0;
               op_data.glyph  = '0;
            end
         end else if (active_ff) begin
            if (req_data.char_code == CHAR_NUL) begin
               active_in      = 1'b0;
               op_push        = 1'b1;
               op_data.kind   = KIND_DONE;
               op_data.line   = '0;
               op_data.column = '0;
               op_data.glyph  = '0;
               op_data.total  = 7'(drawn_ff);
            end else if (bytes_ff < BYTES_W'(BUFFER_BYTES - 1)) begin
               bytes_in = bytes_ff + BYTES_W'(1);
               if (int'(line_ff) <= TEXT_LINES) begin
                  unique case (req_data.char_code)
                     CHAR_CR: begin
                        col_in = COL_W'(1);
                     end
                     CHAR_LF: begin
                        col_in  = COL_W'(1);
                        line_in = line_ff + LINE_W'(1);
                     end
                     default: begin
                        op_push       = 1'b1;
                        op_data.count = OP_COUNT_W'(run_n);
                        if (req_data.char_code == CHAR_TAB) begin
                           op_data.glyph = CHAR_SPACE;
                        end
                        drawn_in = drawn_ff + DRAWN_W'(run_n);
                        if (int'(col_after) > TEXT_COLUMNS) begin
                           col_in  = COL_W'(1);
                           line_in = line_ff + LINE_W'(1);
                        end else begin
                           col_in = col_after;
                        end
                     end
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         line_ff   <= LINE_W'(1);
         col_ff    <= COL_W'(1);
         drawn_ff  <= '0;
         bytes_ff  <= '0;
      end else begin
         active_ff <= active_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         drawn_ff  <= drawn_in;
         bytes_ff  <= bytes_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/tcp_queue.sv -----
// short job queue between front and back end
// depends on tcp_pkg
`default_nettype none

module tcp_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           wr_push,
   input  wire tcp_pkg::op_type wr_data,
   output logic                wr_full,
   input  wire logic           rd_pop,
   output tcp_pkg::op_type     rd_data,
   output logic                rd_empty
);
   import tcp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   op_type            store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_wr, do_rd;

   always_comb begin
      wr_full  = (count_ff == CNT_W'(DEPTH));
      rd_empty = (count_ff == '0);
      rd_data  = store_ff[rd_ptr_ff];
      do_wr    = wr_push && !wr_full;
      do_rd    = rd_pop && !rd_empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (int'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (int'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_wr) - CNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ----- src/tcp_back.sv -----
// back end: expands queued jobs into result items, one per cycle while results are taken, behind an output register
// depends on tcp_pkg
`default_nettype none

module tcp_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            q_empty,
   input  wire tcp_pkg::op_type  q_data,
   output logic                 q_pop,
   output logic                 empty,
   input  wire logic            pop,
   output tcp_pkg::rsp_type     rsp_data
);
   import tcp_pkg::*;

   logic    cur_valid_ff, cur_valid_in;
   op_type  cur_ff, cur_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    advance, final_one, cur_free;

   always_comb begin
      advance   = cur_valid_ff && (!out_valid_ff || pop);
      final_one = (cur_ff.count == OP_COUNT_W'(1));
      cur_free  = !cur_valid_ff || (advance && final_one);
      q_pop     = cur_free && !q_empty;

      out_in             = out_ff;
      out_in.kind        = cur_ff.kind;
      out_in.draw_line   = cur_ff.line;
      out_in.draw_column = cur_ff.column;
      out_in.glyph_code  = cur_ff.glyph;
      out_in.drawn_total = cur_ff.total;
      out_in.last        = final_one;

      out_valid_in = advance ? 1'b1 : (pop ? 1'b0 : out_valid_ff);

      cur_in = cur_ff;
      if (advance && !final_one) begin
         cur_in.count  = cur_ff.count - OP_COUNT_W'(1);
         cur_in.column = cur_ff.column + 5'd1;
      end
      if (q_pop) begin
         cur_in = q_data;
      end
      cur_valid_in = q_pop ? 1'b1 : (cur_free ? 1'b0 : cur_valid_ff);

      empty    = !out_valid_ff;
      rsp_data = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (advance) begin
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/text_cursor_placement.sv -----
// top level of the text cursor placement block
// depends on tcp_pkg, tcp_front, tcp_queue and tcp_back
`default_nettype none

// Cursor engine for a TEXT_LINES x TEXT_COLUMNS character display. A begin item
// opens a string at a start line and column (both from 1); each following
// character byte moves the cursor and produces placements (line, column, glyph).
// CR returns to column 1, LF also moves down one line, TAB pads with spaces to
// the next TAB_STOP column stop, text wraps after the last column, and bytes are
// dropped once the cursor has run past the last line. A zero byte closes the
// string with a done result carrying the draw count; an out-of-range begin gives
// a rejected result. Only the first BUFFER_BYTES-1 nonzero bytes of a string act.
// Timing: the front end takes one item per cycle as long as the job queue
// (QUEUE_DEPTH jobs) has room, and every item settles the cursor in that same
// cycle. The back end emits one result per cycle from an output register while
// results are taken, so a plain character or a status result gives one result
// and a tab up to TAB_STOP results; an item passes through the job queue, the
// current job register and the output register before its first result shows.
module text_cursor_placement #(
   parameter int TEXT_LINES   = 4,
   parameter int TEXT_COLUMNS = 16,
   parameter int TAB_STOP     = 4,
   parameter int BUFFER_BYTES = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // input channel, transfer on push && !full
   input  wire logic             push,
   output logic                  full,
   input  wire tcp_pkg::req_type req_data,
   // result channel, transfer on pop && !empty
   output logic                  empty,
   input  wire logic             pop,
   output tcp_pkg::rsp_type      rsp_data
);
   import tcp_pkg::*;

   logic   req_accept;
   logic   op_push;
   op_type op_data;
   logic   q_full, q_empty, q_pop;
   op_type q_data;

   // the front end only moves when the queue has a free slot, whether or not the item makes a job
   assign full       = q_full;
   assign req_accept = push && !q_full;

   // cursor state and item classification
   tcp_front #(
      .TEXT_LINES  (TEXT_LINES),
      .TEXT_COLUMNS(TEXT_COLUMNS),
      .TAB_STOP    (TAB_STOP),
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_accept(req_accept),
      .req_data  (req_data),
      .op_push   (op_push),
      .op_data   (op_data)
   );

   // decouples item acceptance from result delivery
   tcp_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_push (op_push),
      .wr_data (op_data),
      .wr_full (q_full),
      .rd_pop  (q_pop),
      .rd_data (q_data),
      .rd_empty(q_empty)
   );

   // job expansion and output register
   tcp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .empty   (empty),
      .pop     (pop),
      .rsp_data(rsp_data)
   );

endmodule

`default_nettype wire

// ----- src/tcp_checker.sv -----
// port-level checks for text_cursor_placement, attached by bind
// depends on tcp_pkg and text_cursor_placement
`default_nettype none

module tcp_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             empty,
   input wire logic             pop,
   input wire tcp_pkg::rsp_type rsp_data
);
   import tcp_pkg::*;

   // nothing to show right after reset
   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("results shown after reset");

   // a waiting result holds until its transfer
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed");

   // status results carry no position and always end their item
   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.kind != KIND_DRAW) |->
      (rsp_data.draw_line == 3'd0 && rsp_data.draw_column == 5'd0 &&
       rsp_data.glyph_code == 8'd0 && rsp_data.last))
      else $error("malformed status result");

   // only known kinds, and draws and rejects carry no total
   a_draw_shape: assert property (@(posedge clock) disable iff (reset)
      !empty |->
      ((rsp_data.kind == KIND_DRAW && rsp_data.drawn_total == 7'd0) ||
       rsp_data.kind == KIND_DONE ||
       (rsp_data.kind == KIND_REJECT && rsp_data.drawn_total == 7'd0)))
      else $error("malformed result kind or total");

endmodule

bind text_cursor_placement tcp_checker u_checker (.*);

`default_nettype wire

// ----- tb/sv/tcp_scoreboard_pkg.sv -----
// scoreboard for the text cursor placement block: cursor predictor and result check
// depends on tcp_pkg for the item types, command codes, kinds and character codes
`timescale 1ns / 1ps

package tcp_scoreboard_pkg;
   import tcp_pkg::*;

   localparam int N_LINES   = 4;
   localparam int N_COLUMNS = 16;
   localparam int TAB_WIDTH = 4;
   localparam int BUF_LIMIT = 256;

   class cursor_scoreboard;
      bit          string_open = 1'b0;
      int unsigned line        = 1;
      int unsigned column      = 1;
      int unsigned drawn       = 0;
      int unsigned bytes_taken = 0;
      rsp_type     placement_q[$];
      int          mismatches  = 0;

      function void add_result(logic [1:0] kind, int unsigned ln, int unsigned col,
                               logic [7:0] glyph, int unsigned total);
         rsp_type r;
         r             = '0;
         r.kind        = kind;
         r.draw_line   = 3'(ln);
         r.draw_column = 5'(col);
         r.glyph_code  = glyph;
         r.drawn_total = 7'(total);
         placement_q.push_back(r);
      endfunction

      function void advance_line();
         column = 1;
         if (line <= N_LINES) line++;
      endfunction

      // predict the results of one accepted item
      function void note_input(req_type item);
         int      n_before;
         int      pad;
         rsp_type tail;
         n_before = placement_q.size();
         if (item.command == CMD_BEGIN) begin
            if (item.start_line < 1 || item.start_line > N_LINES ||
                item.start_column < 1 || item.start_column > N_COLUMNS) begin
               string_open = 1'b0;
               add_result(KIND_REJECT, 0, 0, 8'h00, 0);
            end else begin
               string_open = 1'b1;
               line        = item.start_line;
               column      = item.start_column;
               drawn       = 0;
               bytes_taken = 0;
            end
         end else if (string_open) begin
            if (item.char_code == CHAR_NUL) begin
               add_result(KIND_DONE, 0, 0, 8'h00, drawn);
               string_open = 1'b0;
            end else if (bytes_taken < BUF_LIMIT - 1) begin
               bytes_taken++;
               if (line <= N_LINES) begin
                  case (item.char_code)
                     CHAR_CR: column = 1;
                     CHAR_LF: advance_line();
                     CHAR_TAB: begin
                        pad = TAB_WIDTH - ((column - 1) % TAB_WIDTH);
                        for (int s = 0; s < pad && column <= N_COLUMNS; s++) begin
                           add_result(KIND_DRAW, line, column, CHAR_SPACE, 0);
                           column++;
                           drawn++;
                        end
                        if (column > N_COLUMNS) advance_line();
                     end
                     default: begin
                        add_result(KIND_DRAW, line, column, item.char_code, 0);
                        drawn++;
                        column++;
                        if (column > N_COLUMNS) advance_line();
                     end
                  endcase
               end
            end
         end
         if (placement_q.size() > n_before) begin
            tail      = placement_q.pop_back();
            tail.last = 1'b1;
            placement_q.push_back(tail);
         end
      endfunction

      function void report(string why, rsp_type want, rsp_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s: expected kind=%0d line=%0d col=%0d glyph=%02h total=%0d last=%0d, got kind=%0d line=%0d col=%0d glyph=%02h total=%0d last=%0d",
                     $time, why, want.kind, want.draw_line, want.draw_column,
                     want.glyph_code, want.drawn_total, want.last, got.kind,
                     got.draw_line, got.draw_column, got.glyph_code, got.drawn_total,
                     got.last);
      endfunction

      // compare one accepted result with the oldest prediction
      function void check_result(rsp_type got);
         rsp_type want;
         if (placement_q.size() == 0) begin
            report("result with nothing pending", '0, got);
            return;
         end
         want = placement_q.pop_front();
         if (got.kind !== want.kind || got.draw_line !== want.draw_line ||
             got.draw_column !== want.draw_column || got.glyph_code !== want.glyph_code ||
             got.drawn_total !== want.drawn_total || got.last !== want.last)
            report("result field mismatch", want, got);
      endfunction

      function int pending();
         return placement_q.size();
      endfunction
   endclass

endpackage

// ----- tb/sv/testbench.sv -----
// top-level testbench for text_cursor_placement: directed and random strings
// depends on tcp_pkg, tcp_scoreboard_pkg and the text_cursor_placement rtl
`timescale 1ns / 1ps

module testbench;
   import tcp_pkg::*;
   import tcp_scoreboard_pkg::*;

   // generous bound for the whole run
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 130;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   logic    pop      = 1'b0;
   req_type req_data = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_data;

   cursor_scoreboard sb = new;

   // idling on both sides, off for stretches and for the closing part
   bit idle_on     = 1'b0;
   int cycle_count = 0;
   int random_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_cursor_placement dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // watchdog, any hang ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // transfer monitor, values sampled are the ones before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) sb.note_input(req_data);
         if (pop && !empty) sb.check_result(rsp_data);
      end
   end

   // result side: pop high except for random stall bursts
   initial begin
      @(negedge reset);
      forever begin
         if (idle_on && $urandom_range(0, 7) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
      end
   end

   // one input transfer, with an optional gap in front of it
   task automatic send_item(input req_type item);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (full);
   endtask

   // begin item, the unused byte field carries random bits
   task automatic send_begin(input int ln, input int col);
      req_type item;
      item.command      = CMD_BEGIN;
      item.start_line   = 3'(ln);
      item.start_column = 5'(col);
      item.char_code    = 8'($urandom_range(0, 255));
      send_item(item);
   endtask

   // character item, the unused position fields carry random bits
   task automatic send_char(input logic [7:0] code);
      req_type item;
      item.command      = CMD_CHAR;
      item.start_line   = 3'($urandom_range(0, 7));
      item.start_column = 5'($urandom_range(0, 31));
      item.char_code    = code;
      send_item(item);
   endtask

   // nonzero text byte, weighted toward the cursor controls
   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return CHAR_TAB;
      if (r < 20) return CHAR_CR;
      if (r < 28) return CHAR_LF;
      if (r < 70) return 8'($urandom_range(8'h21, 8'h7e));
      return 8'($urandom_range(1, 255));
   endfunction

   // mostly well-formed strings, some bad begins and some left open
   task automatic random_string();
      int len;
      if ($urandom_range(0, 9) != 0)
         send_begin($urandom_range(1, N_LINES), $urandom_range(1, N_COLUMNS));
      else
         send_begin($urandom_range(0, 7), $urandom_range(0, 31));
      random_sent++;
      len = $urandom_range(0, 24);
      repeat (len) begin
         send_char(pick_byte());
         random_sent++;
      end
      if ($urandom_range(0, 6) != 0) begin
         send_char(CHAR_NUL);
         random_sent++;
         // noise: bytes with no string open
         if ($urandom_range(0, 9) == 0)
            send_char(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // begins out of range on either field, extremes included
      send_begin(0, 5);
      send_begin(5, 1);
      send_begin(3, 0);
      send_begin(2, 17);
      send_begin(7, 31);
      // bytes with no string open are ignored, a zero byte too
      send_char(8'h5a);
      send_char(CHAR_NUL);
      // plain char, tab mid-stop, cr then lf, full tab, top and low byte codes
      send_begin(1, 1);
      send_char(8'h41);
      send_char(CHAR_TAB);
      send_char(CHAR_CR);
      send_char(CHAR_LF);
      send_char(CHAR_TAB);
      send_char(8'hff);
      send_char(8'h01);
      send_char(CHAR_NUL);
      // tab that fills up to the last column, then the line runs off the screen
      send_begin(4, 15);
      send_char(CHAR_TAB);
      send_char(8'h79);
      send_char(CHAR_LF);
      send_char(CHAR_NUL);
      // begin while a string is open drops it; char at last column wraps
      send_begin(2, 3);
      send_char(8'h61);
      send_begin(1, 16);
      send_char(8'h62);
      send_char(CHAR_NUL);

      // random part, idling switched on and off per string
      idle_on = 1'b1;
      while (random_sent < RANDOM_ITEMS - 40) begin
         idle_on = ($urandom_range(0, 3) != 0);
         random_string();
      end
      // closing part without any idling
      idle_on = 1'b0;
      while (random_sent < RANDOM_ITEMS)
         random_string();
      send_char(CHAR_NUL);
      push <= 1'b0;

      // drain, then allow for late extra results
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ----- text_cursor_placement.f -----
src/tcp_pkg.sv
src/tcp_front.sv
src/tcp_queue.sv
src/tcp_back.sv
src/text_cursor_placement.sv
src/tcp_checker.sv
tb/sv/tcp_scoreboard_pkg.sv
tb/sv/testbench.sv
